// ===== rtl/core/trlt_pkg.sv =====
package trlt_pkg;

  // Table geometry.
  localparam int CAPACITY = 64;
  localparam int MAX_OUT  = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int TAKEN_W  = $clog2(MAX_OUT + 1);

  // Item field widths.
  localparam int KEY_W  = 56;
  localparam int ID_W   = 32;
  localparam int GRAN_W = 3;

  // Packed time layout: seven-bit fields above a seven-bit unused slot.
  localparam int FIELD_W    = 7;
  localparam int FINE_FIELDS = 5;
  localparam logic [FIELD_W-1:0] FIELD_TOP = 7'd100;

  // Operation codes.
  localparam logic OP_PUT      = 1'b0;
  localparam logic OP_RETRIEVE = 1'b1;

  // Commands that the sequencer sends along the row of cells.
  typedef struct packed {
    logic rotate;   // every cell takes its right neighbor's entry
    logic update;   // the matching cell takes the new id
    logic insert;   // open a slot at the sorted place and write the new entry
  } trlt_ctrl_t;

  // Range start: low slot and every field finer than the granularity cleared.
  function automatic logic [KEY_W-1:0] range_lo(input logic [KEY_W-1:0] t,
                                                input logic [GRAN_W-1:0] gra);
    logic [KEY_W-1:0] r;
    int g;
    r = t;
    g = int'(gra);
    r[FIELD_W-1:0] = '0;
    for (int f = 1; f <= FINE_FIELDS; f++) begin
      if (g < FINE_FIELDS && f <= FINE_FIELDS - g) begin
        r[FIELD_W*f +: FIELD_W] = '0;
      end
    end
    return r;
  endfunction

  // Range end: low slot cleared, every field finer than the granularity at the top value.
  function automatic logic [KEY_W-1:0] range_hi(input logic [KEY_W-1:0] t,
                                                input logic [GRAN_W-1:0] gra);
    logic [KEY_W-1:0] r;
    int g;
    r = t;
    g = int'(gra);
    r[FIELD_W-1:0] = '0;
    for (int f = 1; f <= FINE_FIELDS; f++) begin
      if (g < FINE_FIELDS && f <= FINE_FIELDS - g) begin
        r[FIELD_W*f +: FIELD_W] = FIELD_TOP;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/timestamp_range_log_table.sv =====
// Timestamp range log table.
// Command channel: drive operation, entry_id, time_a, time_b and granularity
// with start high; the item is taken at a clock edge where busy is low.
// A put stores entry_id under key time_a in a sorted row of cells and gives
// one result (hit 0, last 1, dropped set when the row is full and the key is new).
// A retrieve gives the ids of stored keys in the masked range, ascending,
// one result per cycle at most, with last on the final one; an empty range
// gives one result with hit 0 and last 1.
// Results appear for one cycle each with strobe high; the receiver cannot stall.
// A put passes through the S_PUT state, which registers its result.
// A retrieve rotates the whole row once past the comparator at cell 0
// in S_SCAN, then closes in S_FLUSH; busy stays high through both states.
// One entry of the row reaches the comparator per cycle during the scan.
// Reset empties the table and returns the block to idle at once.
module timestamp_range_log_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [trlt_pkg::ID_W-1:0]     entry_id,
  input  logic [trlt_pkg::KEY_W-1:0]    time_a,
  input  logic [trlt_pkg::KEY_W-1:0]    time_b,
  input  logic [trlt_pkg::GRAN_W-1:0]   granularity,
  output logic                          strobe,
  output logic [trlt_pkg::ID_W-1:0]     result_id,
  output logic                          hit,
  output logic                          last,
  output logic                          dropped
);
  import trlt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PUT   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] entry_count;
  logic [IDX_W-1:0]   scan_idx;
  logic [TAKEN_W-1:0] taken;
  logic [KEY_W-1:0]   op_key;
  logic [KEY_W-1:0]   hi_key;
  logic [ID_W-1:0]    op_id;
  logic               pend_valid;
  logic [ID_W-1:0]    pend_id;

  trlt_ctrl_t         ctrl;
  logic [KEY_W-1:0]   cell_key [CAPACITY];
  logic [ID_W-1:0]    cell_id  [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;
  logic               any_eq;
  logic               full;
  logic               scan_match;
  logic               scan_end;

  assign busy     = (state != S_IDLE);
  assign any_eq   = |cell_eq;
  assign full     = (entry_count == COUNT_W'(CAPACITY));
  assign scan_end = (scan_idx == IDX_W'(CAPACITY - 1));

  // The entry now at cell 0 came from position scan_idx before the rotation.
  assign scan_match = (COUNT_W'(scan_idx) < entry_count) &&
                      (cell_key[0] >= op_key) && (cell_key[0] <= hi_key) &&
                      (taken < TAKEN_W'(MAX_OUT));

  // Commands to the row.
  always_comb begin
    ctrl        = '0;
    ctrl.rotate = (state == S_SCAN);
    ctrl.update = (state == S_PUT) && any_eq;
    ctrl.insert = (state == S_PUT) && !any_eq && !full;
  end

  // The row of cells: inserts shift right, the scan rotates left.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic live;
    assign live = (COUNT_W'(i) < entry_count);
    if (i == 0) begin : g_first
      trlt_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .live     (live),
        .new_key  (op_key),
        .new_id   (op_id),
        .prev_lt  (1'b1),
        .prev_key (op_key),
        .prev_id  (op_id),
        .next_key (cell_key[(i + 1) % CAPACITY]),
        .next_id  (cell_id[(i + 1) % CAPACITY]),
        .key      (cell_key[i]),
        .id       (cell_id[i]),
        .lt       (cell_lt[i]),
        .eq       (cell_eq[i])
      );
    end else begin : g_rest
      trlt_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .live     (live),
        .new_key  (op_key),
        .new_id   (op_id),
        .prev_lt  (cell_lt[i-1]),
        .prev_key (cell_key[i-1]),
        .prev_id  (cell_id[i-1]),
        .next_key (cell_key[(i + 1) % CAPACITY]),
        .next_id  (cell_id[(i + 1) % CAPACITY]),
        .key      (cell_key[i]),
        .id       (cell_id[i]),
        .lt       (cell_lt[i]),
        .eq       (cell_eq[i])
      );
    end
  end

  // Operand registers, loaded when an item is taken.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_id <= entry_id;
      if (operation == OP_RETRIEVE) begin
        op_key <= range_lo(time_a, granularity);
        hi_key <= range_hi(time_b, granularity);
      end else begin
        op_key <= range_lo(time_a, GRAN_W'(FINE_FIELDS));
        hi_key <= '0;
      end
    end
  end

  // Sequencer, fill count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      scan_idx    <= '0;
      taken       <= '0;
      pend_valid  <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            scan_idx   <= '0;
            taken      <= '0;
            pend_valid <= 1'b0;
            state      <= (operation == OP_RETRIEVE) ? S_SCAN : S_PUT;
          end
        end
        S_PUT: begin
          if (!any_eq && !full) begin
            entry_count <= entry_count + COUNT_W'(1);
          end
          strobe    <= 1'b1;
          result_id <= '0;
          hit       <= 1'b0;
          last      <= 1'b1;
          dropped   <= !any_eq && full;
          state     <= S_IDLE;
        end
        S_SCAN: begin
          // A new match releases the one held back, which is then not the last.
          if (scan_match) begin
            taken      <= taken + TAKEN_W'(1);
            pend_valid <= 1'b1;
            pend_id    <= cell_id[0];
            if (pend_valid) begin
              strobe    <= 1'b1;
              result_id <= pend_id;
              hit       <= 1'b1;
              last      <= 1'b0;
              dropped   <= 1'b0;
            end
          end
          scan_idx <= scan_idx + IDX_W'(1);
          if (scan_end) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          strobe    <= 1'b1;
          result_id <= pend_valid ? pend_id : '0;
          hit       <= pend_valid;
          last      <= 1'b1;
          dropped   <= 1'b0;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/trlt_cell.sv =====
module trlt_cell (
  input  logic                      clk,
  input  trlt_pkg::trlt_ctrl_t      ctrl,
  input  logic                      live,
  input  logic [trlt_pkg::KEY_W-1:0] new_key,
  input  logic [trlt_pkg::ID_W-1:0]  new_id,
  input  logic                      prev_lt,
  input  logic [trlt_pkg::KEY_W-1:0] prev_key,
  input  logic [trlt_pkg::ID_W-1:0]  prev_id,
  input  logic [trlt_pkg::KEY_W-1:0] next_key,
  input  logic [trlt_pkg::ID_W-1:0]  next_id,
  output logic [trlt_pkg::KEY_W-1:0] key,
  output logic [trlt_pkg::ID_W-1:0]  id,
  output logic                      lt,
  output logic                      eq
);
  import trlt_pkg::*;

  // Compare the held entry with the new key; empty cells never match.
  assign lt = live && (key < new_key);
  assign eq = live && (key == new_key);

  // One entry of the sorted row.
  always_ff @(posedge clk) begin
    priority if (ctrl.rotate) begin
      key <= next_key;
      id  <= next_id;
    end else if (ctrl.update) begin
      if (eq) begin
        id <= new_id;
      end
    end else if (ctrl.insert) begin
      if (!lt) begin
        if (prev_lt) begin
          key <= new_key;
          id  <= new_id;
        end else begin
          key <= prev_key;
          id  <= prev_id;
        end
      end
    end else begin
      // No command: the entry holds.
      key <= key;
      id  <= id;
    end
  end

endmodule
